/* hw/rtl/wpp_pkg.sv */
`timescale 1ns / 1ps

package wpp_pkg;

  // Fixed field widths of the command and result channels.
  localparam int OP_W     = 1;
  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int DRAW_W   = 32;
  localparam int CNT_W    = 7;
  localparam int CFG_IDX_W = 1;

  // Defaults for the table geometry.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Reset value of both count registers.
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd41;

  // Command opcodes.
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_DRAW  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sum;
    logic div_start;
    logic row_start;
    logic row;
    logic col;
    logic emit_none;
  } wpp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_done;
    logic total_zero;
    logic div_done;
    logic row_done;
    logic col_done;
  } wpp_sts_t;

endpackage

/* hw/rtl/wpp_div.sv */
`timescale 1ns / 1ps

// Restoring divider that delivers only the remainder, one quotient bit per cycle.
module wpp_div #(
  parameter int DW = 32,
  parameter int TW = 28
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [TW-1:0] divisor,
  output logic          done,
  output logic [TW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW-1:0] dvd_r;
  logic [TW-1:0] dsr_r;
  logic [TW-1:0] rem_r;
  logic [TW:0]   shifted;
  logic [TW:0]   diff;

  assign shifted = {rem_r, dvd_r[DW-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      if (!diff[TW]) begin
        rem_r <= diff[TW-1:0];
      end else begin
        rem_r <= shifted[TW-1:0];
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* hw/rtl/wpp_dp.sv */
`timescale 1ns / 1ps

module wpp_dp
  import wpp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wpp_cmd_t            cmd,
  output wpp_sts_t            sts,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_row,
  input  logic [IDX_W-1:0]    wr_col,
  input  logic [WEIGHT_W-1:0] wr_weight,
  input  logic [DRAW_W-1:0]   draw,
  input  logic [CNT_W-1:0]    rows_cfg,
  input  logic [CNT_W-1:0]    cols_cfg,
  output logic                res_valid,
  output logic                res_found,
  output logic [IDX_W-1:0]    res_row,
  output logic [IDX_W-1:0]    res_col
);

  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = WEIGHT_W + AW;

  function automatic logic [AW-1:0] entry_addr(input logic [RIW-1:0] row,
                                               input logic [CIW-1:0] col);
    return AW'(row) * AW'(MAX_COLS) + AW'(col);
  endfunction

  // Weight table and the running row totals of the current draw.
  logic [WEIGHT_W-1:0] wmem [0:DEPTH-1];
  logic [TW-1:0]       rmem [0:MAX_ROWS-1];

  logic [WEIGHT_W-1:0] wq_r;
  logic [TW-1:0]       rq_r;

  logic [RIW-1:0] nr_m1_r;
  logic [CIW-1:0] nc_m1_r;
  logic [DRAW_W-1:0] draw_r;

  logic [RIW-1:0] sx_r;
  logic [CIW-1:0] sy_r;
  logic           issue_on_r;
  logic           rd_vld_r;
  logic [RIW-1:0] rd_row_r;
  logic [CIW-1:0] rd_col_r;
  logic           rd_eol_r;
  logic           rd_last_r;

  logic [RIW-1:0] rx_r;
  logic           row_on_r;
  logic           rv_r;
  logic [RIW-1:0] rk_r;

  logic [TW-1:0] total_r;
  logic [TW-1:0] acc_r;
  logic [TW-1:0] r_r;
  logic [TW-1:0] prev_r;

  logic          res_valid_r;
  logic          res_found_r;
  logic [IDX_W-1:0] res_row_r;
  logic [IDX_W-1:0] res_col_r;

  logic [TW-1:0] div_rem;
  logic          div_done;

  logic          wr_ok;
  logic          issue;
  logic [CNT_W+1:0] rows_w;
  logic [CNT_W+1:0] cols_w;
  logic [RIW-1:0]   nr_m1_nxt;
  logic [CIW-1:0]   nc_m1_nxt;
  logic [TW-1:0]    sum_nxt;
  logic [TW-1:0]    acc_nxt;
  logic             row_cont;
  logic             col_stop;
  logic             row_hit;
  logic             col_hit;

  assign wr_ok = wr_en && (32'(wr_row) < MAX_ROWS) && (32'(wr_col) < MAX_COLS);
  assign issue = issue_on_r && (cmd.sum || cmd.col);

  // Count registers: zero acts as one, anything above the table size saturates.
  assign rows_w = {2'b00, rows_cfg};
  assign cols_w = {2'b00, cols_cfg};

  always_comb begin
    if (rows_cfg == '0) begin
      nr_m1_nxt = '0;
    end else if (rows_w > (CNT_W+2)'(MAX_ROWS)) begin
      nr_m1_nxt = RIW'(MAX_ROWS - 1);
    end else begin
      nr_m1_nxt = RIW'(rows_w - 1'b1);
    end
    if (cols_cfg == '0) begin
      nc_m1_nxt = '0;
    end else if (cols_w > (CNT_W+2)'(MAX_COLS)) begin
      nc_m1_nxt = CIW'(MAX_COLS - 1);
    end else begin
      nc_m1_nxt = CIW'(cols_w - 1'b1);
    end
  end

  assign sum_nxt  = total_r + TW'(wq_r);
  assign acc_nxt  = acc_r + TW'(wq_r);
  assign row_cont = (rk_r != nr_m1_r) && (r_r >= rq_r);
  assign col_stop = (rd_col_r == nc_m1_r) || (acc_nxt > r_r);
  assign row_hit  = cmd.row && rv_r && !row_cont;
  assign col_hit  = cmd.col && rd_vld_r && col_stop;

  // Memories.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      wmem[entry_addr(RIW'(wr_row), CIW'(wr_col))] <= wr_weight;
    end
    if (issue) begin
      wq_r <= wmem[entry_addr(sx_r, sy_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum && rd_vld_r && rd_eol_r) begin
      rmem[rd_row_r] <= sum_nxt;
    end
    if (cmd.row && row_on_r) begin
      rq_r <= rmem[rx_r];
    end
  end

  // Sequencing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_on_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      row_on_r    <= 1'b0;
      rv_r        <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      rx_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= issue;
      rv_r        <= row_on_r && cmd.row;
      res_valid_r <= cmd.emit_none || col_hit;
      if (cmd.load) begin
        sx_r       <= '0;
        sy_r       <= '0;
        issue_on_r <= 1'b1;
      end else if (issue) begin
        if (sy_r == nc_m1_r) begin
          sy_r <= '0;
          if (cmd.col || sx_r == nr_m1_r) begin
            issue_on_r <= 1'b0;
          end else begin
            sx_r <= sx_r + 1'b1;
          end
        end else begin
          sy_r <= sy_r + 1'b1;
        end
      end
      if (col_hit) begin
        issue_on_r <= 1'b0;
      end
      if (cmd.row_start) begin
        rx_r     <= '0;
        row_on_r <= 1'b1;
      end else if (row_hit) begin
        row_on_r   <= 1'b0;
        sx_r       <= rk_r;
        sy_r       <= '0;
        issue_on_r <= 1'b1;
      end else if (cmd.row && row_on_r) begin
        if (rx_r == nr_m1_r) begin
          row_on_r <= 1'b0;
        end else begin
          rx_r <= rx_r + 1'b1;
        end
      end
    end
  end

  // Arithmetic registers and read tags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nr_m1_r <= nr_m1_nxt;
      nc_m1_r <= nc_m1_nxt;
      draw_r  <= draw;
      total_r <= '0;
    end
    if (issue) begin
      rd_row_r  <= sx_r;
      rd_col_r  <= sy_r;
      rd_eol_r  <= (sy_r == nc_m1_r);
      rd_last_r <= (sy_r == nc_m1_r) && (sx_r == nr_m1_r);
    end
    if (cmd.sum && rd_vld_r) begin
      total_r <= sum_nxt;
    end
    if (cmd.row && row_on_r) begin
      rk_r <= rx_r;
    end
    if (cmd.row_start) begin
      r_r    <= div_rem;
      prev_r <= '0;
    end else if (row_hit) begin
      r_r   <= r_r - prev_r;
      acc_r <= '0;
    end else if (cmd.row && rv_r) begin
      prev_r <= rq_r;
    end
    if (cmd.col && rd_vld_r && !col_stop) begin
      acc_r <= acc_nxt;
    end
    if (cmd.emit_none) begin
      res_found_r <= 1'b0;
      res_row_r   <= '0;
      res_col_r   <= '0;
    end else if (col_hit) begin
      res_found_r <= 1'b1;
      res_row_r   <= IDX_W'(sx_r);
      res_col_r   <= IDX_W'(rd_col_r);
    end
  end

  wpp_div #(
    .DW(DRAW_W),
    .TW(TW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (draw_r),
    .divisor  (total_r),
    .done     (div_done),
    .remainder(div_rem)
  );

  assign sts.sum_done   = cmd.sum && rd_vld_r && rd_last_r;
  assign sts.total_zero = (total_r == '0);
  assign sts.div_done   = div_done;
  assign sts.row_done   = row_hit;
  assign sts.col_done   = col_hit;

  assign res_valid = res_valid_r;
  assign res_found = res_found_r;
  assign res_row   = res_row_r;
  assign res_col   = res_col_r;

  a_rem_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_start |-> (div_rem < total_r))
    else $error("remainder is not below the weight total");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_found_r) |-> (res_row_r == '0 && res_col_r == '0))
    else $error("empty pick carries a nonzero index");

  a_row_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    row_hit |-> (rk_r <= nr_m1_r))
    else $error("picked row lies beyond the rows in use");

  a_col_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    col_hit |-> (rd_col_r <= nc_m1_r && rd_row_r == sx_r))
    else $error("picked column lies beyond the columns in use");

endmodule

/* hw/rtl/wpp_ctrl.sv */
`timescale 1ns / 1ps

module wpp_ctrl
  import wpp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] opcode,
  input  wpp_sts_t        sts,
  output wpp_cmd_t        cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;
  localparam logic [2:0] S_COL  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start && opcode == OP_DRAW) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.total_zero) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.row_start = 1'b1;
          state_nxt     = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row = 1'b1;
        if (sts.row_done) begin
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        cmd.col = 1'b1;
        if (sts.col_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hw/rtl/weighted_pair_picker_top.sv */
`timescale 1ns / 1ps

// Weighted pair picker: holds a table of 16-bit weights and picks a (row, column)
// pair with probability proportional to its weight, given a uniform draw value.
// Commands are transferred at a rising edge with start high and busy low. A write
// command (opcode write) stores one weight in that cycle, produces no result and
// leaves busy low, so writes can be issued every cycle. A draw command raises busy;
// its single result is shown on the out_ ports for one cycle, marked by out_valid,
// in the first cycle in which busy is low again, so the next command can be
// transferred at the edge that takes the result. The receiver cannot stall.
// After a draw is transferred, busy stays high through these steps in order: the
// sum pass reads every weight in use through the single read port of the weight
// memory, a check state follows, the restoring divider takes the draw modulo the
// total, and the row walk and then the column walk find the picked row and column.
// A draw whose total is zero ends after the check state.
// Configuration writes are transferred on the cfg_ channel, which is always ready;
// they must only be issued while the block is idle. Reset sets both count registers
// to 41; the weight memory is not cleared, so every entry in use must be written.
module weighted_pair_picker_top
  import wpp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [IDX_W-1:0]     in_row_index,
  input  logic [IDX_W-1:0]     in_col_index,
  input  logic [WEIGHT_W-1:0]  in_weight,
  input  logic [DRAW_W-1:0]    in_draw,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [IDX_W-1:0]     out_pick_row,
  output logic [IDX_W-1:0]     out_pick_col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  wpp_cmd_t cmd;
  wpp_sts_t sts;

  logic [CNT_W-1:0] rows_r;
  logic [CNT_W-1:0] cols_r;
  logic             cfg_xfer;
  logic             cmd_xfer;
  logic             wr_en;

  // The configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_RESET;
      cols_r <= CNT_RESET;
    end else if (cfg_xfer) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A weight write is a command transfer with the write opcode.
  assign cmd_xfer = start && !busy;
  assign wr_en    = cmd_xfer && (in_opcode == OP_WRITE);

  wpp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd_xfer),
    .opcode(in_opcode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  wpp_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .wr_en    (wr_en),
    .wr_row   (in_row_index),
    .wr_col   (in_col_index),
    .wr_weight(in_weight),
    .draw     (in_draw),
    .rows_cfg (rows_r),
    .cols_cfg (cols_r),
    .res_valid(out_valid),
    .res_found(out_found),
    .res_row  (out_pick_row),
    .res_col  (out_pick_col)
  );

endmodule

/* sim/tb_weighted_pair_picker_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the weighted pair picker. A directed table walks
// the all-zero total, the extremes of every field and the writes that fall
// outside the rows and columns in use. Random phases then sweep the count
// registers through their extremes, including zero and values above the
// table size. Each draw result is taken from the directed table or predicted
// from a private weight table copy and compared field by field in arrival order.
module tb_weighted_pair_picker_top;
  import wpp_pkg::*;

  localparam int NROWS       = DEF_MAX_ROWS;
  localparam int NCOLS       = DEF_MAX_COLS;
  localparam int STALL_LIMIT = 20000;
  localparam int N_DIRECTED  = 22;
  localparam int N_PHASES    = 12;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } pick_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [WEIGHT_W-1:0] weight;
    logic [DRAW_W-1:0]   draw;
  } cmd_t;

  // One row of the directed table. When typed is set, the pick given here
  // is the expectation; otherwise the predictor supplies it.
  typedef struct packed {
    cmd_t  cmd;
    logic  typed;
    pick_t pick;
  } dir_row_t;

  // The directed part runs with two rows and two columns in use. The four
  // entries in use are cleared first so that the total is zero, then a
  // single maximum weight and a single unit weight make the pick obvious.
  // Writes to the far corners of the table must not disturb the draws.
  localparam dir_row_t DIR_TABLE [0:N_DIRECTED-1] = '{
    '{'{OP_WRITE, 6'd0,  6'd0,  16'h0000, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd0,  6'd1,  16'h0000, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd1,  6'd0,  16'h0000, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd1,  6'd1,  16'h0000, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0000}, 1'b1, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd1,  6'd1,  16'hFFFF, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'hFFFF_FFFF}, 1'b1, '{1'b1, 6'd1, 6'd1}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0000}, 1'b1, '{1'b1, 6'd1, 6'd1}},
    '{'{OP_WRITE, 6'd0,  6'd0,  16'h0001, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0000}, 1'b1, '{1'b1, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0001}, 1'b1, '{1'b1, 6'd1, 6'd1}},
    '{'{OP_WRITE, 6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd0,  6'd63, 16'hAAAA, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd63, 6'd0,  16'h5555, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0001_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd0,  6'd1,  16'h0002, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd1,  6'd0,  16'h0003, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h8000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h7FFF_FFFF}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_WRITE, 6'd1,  6'd1,  16'h0000, 32'h0000_0000}, 1'b0, '{1'b0, 6'd0, 6'd0}},
    '{'{OP_DRAW,  6'd0,  6'd0,  16'h0000, 32'h0000_0005}, 1'b0, '{1'b0, 6'd0, 6'd0}}
  };

  // Count register settings of the random phases. Zero must act as one and
  // anything above the table size must saturate to it.
  localparam logic [CNT_W-1:0] PHASE_ROWS [0:N_PHASES-1] = '{
    7'd0, 7'd127, 7'd1, 7'd64, 7'd3, 7'd8, 7'd5, 7'd2, 7'd16, 7'd6, 7'd4, 7'd12
  };
  localparam logic [CNT_W-1:0] PHASE_COLS [0:N_PHASES-1] = '{
    7'd0, 7'd1, 7'd127, 7'd2, 7'd5, 7'd8, 7'd3, 7'd64, 7'd4, 7'd6, 7'd1, 7'd10
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_opcode;
  logic [IDX_W-1:0]     in_row_index;
  logic [IDX_W-1:0]     in_col_index;
  logic [WEIGHT_W-1:0]  in_weight;
  logic [DRAW_W-1:0]    in_draw;
  logic                 out_valid;
  logic                 out_found;
  logic [IDX_W-1:0]     out_pick_row;
  logic [IDX_W-1:0]     out_pick_col;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  // Shadow of the block's state: the weight table, which entries have been
  // written, and the two count registers as last written.
  logic [WEIGHT_W-1:0] weight_shadow [NROWS][NCOLS];
  bit                  entry_written [NROWS][NCOLS];
  logic [CNT_W-1:0]    rows_reg;
  logic [CNT_W-1:0]    cols_reg;

  // Picks still owed by the block, oldest first.
  pick_t pending_picks [$];
  pick_t want_pick;
  int    err_count;
  int    stall_cycles;
  int    send_gap_pct;

  weighted_pair_picker_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_weight    (in_weight),
    .in_draw      (in_draw),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_pick_row (out_pick_row),
    .out_pick_col (out_pick_col),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // A count of zero behaves as one and a count beyond the table saturates.
  function automatic int unsigned eff_count(input logic [CNT_W-1:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Roulette-wheel pick over the shadow table: running row totals pick the
  // row, then the remainder of the draw walks the columns of that row. The
  // last row and the last column in use catch whatever is left.
  function automatic pick_t roulette_pick(input logic [DRAW_W-1:0] draw);
    int unsigned nr;
    int unsigned nc;
    int unsigned x;
    int unsigned y;
    logic [31:0] total;
    logic [31:0] r;
    logic [31:0] acc;
    logic [31:0] row_end [NROWS];
    pick_t       p;
    nr    = eff_count(rows_reg, NROWS);
    nc    = eff_count(cols_reg, NCOLS);
    total = '0;
    for (x = 0; x < nr; x++) begin
      for (y = 0; y < nc; y++) total += weight_shadow[x][y];
      row_end[x] = total;
    end
    p = '0;
    if (total == '0) return p;
    r = draw % total;
    x = 0;
    while (x + 1 < nr && r >= row_end[x]) x++;
    if (x > 0) r -= row_end[x-1];
    acc = '0;
    y   = 0;
    while (y + 1 < nc) begin
      acc += weight_shadow[x][y];
      if (acc > r) break;
      y++;
    end
    p.found = 1'b1;
    p.row   = x[IDX_W-1:0];
    p.col   = y[IDX_W-1:0];
    return p;
  endfunction

  // Weights lean toward small values so that zero-weight rows and columns
  // sit next to live ones, with the extremes mixed in.
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int unsigned k;
    k = $urandom_range(99, 0);
    if (k < 20) return '0;
    if (k < 60) return WEIGHT_W'($urandom_range(15, 1));
    if (k < 70) return '1;
    if (k < 80) return WEIGHT_W'($urandom_range(255, 16));
    return WEIGHT_W'($urandom);
  endfunction

  function automatic logic [DRAW_W-1:0] rand_draw();
    int unsigned k;
    k = $urandom_range(99, 0);
    if (k < 5) return '0;
    if (k < 10) return '1;
    if (k < 35) return DRAW_W'($urandom_range(300, 0));
    return DRAW_W'($urandom);
  endfunction

  // Offers one command and holds it until the block takes it. start is not
  // lowered after a transfer, so back-to-back commands keep it high; it is
  // lowered only by a sender gap or by wait_idle.
  task automatic send_cmd(input cmd_t c, input bit typed, input pick_t typed_pick);
    pick_t next_pick;
    while ($urandom_range(99, 0) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_opcode    <= c.op;
    in_row_index <= c.row;
    in_col_index <= c.col;
    in_weight    <= c.weight;
    in_draw      <= c.draw;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    // The transfer happened at this edge, so the shadow moves on with it.
    if (c.op == OP_DRAW) begin
      next_pick     = typed ? typed_pick : roulette_pick(c.draw);
      pending_picks = {pending_picks, next_pick};
    end else begin
      weight_shadow[c.row][c.col] = c.weight;
      entry_written[c.row][c.col] = 1'b1;
    end
  endtask

  // Stops sending until every owed pick has come back and the block has
  // dropped busy. A spare wait at the end covers a write still in flight.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_picks.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROWS) rows_reg = data;
    else cols_reg = data;
  endtask

  task automatic cfg_set(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
    cfg_write(CFG_ROWS, rows);
    cfg_write(CFG_COLS, cols);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: reprogram the counts while idle, make sure every
  // entry in use holds a written weight, then mix draws, writes inside the
  // area in use and writes anywhere in the table.
  task automatic run_phase(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                           input int n_items);
    int unsigned nr;
    int unsigned nc;
    int unsigned k;
    cmd_t        c;
    wait_idle();
    cfg_set(rows, cols);
    nr = eff_count(rows, NROWS);
    nc = eff_count(cols, NCOLS);
    for (int x = 0; x < nr; x++) begin
      for (int y = 0; y < nc; y++) begin
        if (!entry_written[x][y]) begin
          c = '{OP_WRITE, IDX_W'(x), IDX_W'(y), rand_weight(), DRAW_W'($urandom)};
          send_cmd(c, 1'b0, '0);
        end
      end
    end
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99, 0);
      c.draw   = DRAW_W'($urandom);
      c.weight = rand_weight();
      if (k < 45) begin
        c.op   = OP_DRAW;
        c.row  = IDX_W'($urandom);
        c.col  = IDX_W'($urandom);
        c.draw = rand_draw();
      end else if (k < 85) begin
        c.op  = OP_WRITE;
        c.row = IDX_W'($urandom_range(nr - 1, 0));
        c.col = IDX_W'($urandom_range(nc - 1, 0));
      end else begin
        c.op  = OP_WRITE;
        c.row = IDX_W'($urandom);
        c.col = IDX_W'($urandom);
      end
      send_cmd(c, 1'b0, '0);
      // Now and then let the block drain completely before going on.
      if ($urandom_range(39, 0) == 0) wait_idle();
    end
  endtask

  // Each strobed result is taken at the edge that ends its cycle and is
  // checked against the oldest owed pick.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result found=%0d row=%0d col=%0d", $time,
                 out_found, out_pick_row, out_pick_col);
        err_count++;
      end else begin
        want_pick = pending_picks.pop_front();
        if (out_found !== want_pick.found) begin
          $display("%0t: found mismatch, expected %0d, actual %0d", $time,
                   want_pick.found, out_found);
          err_count++;
        end
        if (out_pick_row !== want_pick.row) begin
          $display("%0t: pick_row mismatch, expected %0d, actual %0d", $time,
                   want_pick.row, out_pick_row);
          err_count++;
        end
        if (out_pick_col !== want_pick.col) begin
          $display("%0t: pick_col mismatch, expected %0d, actual %0d", $time,
                   want_pick.col, out_pick_col);
          err_count++;
        end
      end
    end
  end

  // Watchdog: any command, result or register transfer restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_opcode    <= OP_WRITE;
    in_row_index <= '0;
    in_col_index <= '0;
    in_weight    <= '0;
    in_draw      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_ROWS;
    cfg_data     <= '0;
    err_count    = 0;
    stall_cycles = 0;
    send_gap_pct = 0;
    rows_reg     = CNT_RESET;
    cols_reg     = CNT_RESET;
    for (int x = 0; x < NROWS; x++) begin
      for (int y = 0; y < NCOLS; y++) begin
        weight_shadow[x][y] = '0;
        entry_written[x][y] = 1'b0;
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, back to back, on a two by two area.
    cfg_set(7'd2, 7'd2);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_cmd(DIR_TABLE[i].cmd, DIR_TABLE[i].typed, DIR_TABLE[i].pick);
    end

    // Random phases: a light sender gap first, then a heavy one, then none.
    for (int p = 0; p < N_PHASES; p++) begin
      send_gap_pct = (p < 4) ? 24 : ((p < 8) ? 85 : 0);
      run_phase(PHASE_ROWS[p], PHASE_COLS[p], 90);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending_picks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
